// ===== rtl/bb3_pkg.sv =====
// Shared types, constants and the reciprocal table for the 3x3 box blur block.
// Used by the controller, the datapath, the rounding divider and the checker.
// Depends on nothing else.
`default_nettype none

package bb3_pkg;

	localparam int PIX_W       = 8;
	localparam int POS_W       = 10;
	localparam int CFG_W       = 11;
	localparam int SUM_W       = 12;
	localparam int CNT_W       = 4;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 20;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_FRAME_WIDTH  = 1'b0;
	localparam reg_idx_t REG_FRAME_HEIGHT = 1'b1;

	typedef logic [0:0] kind_t;
	localparam kind_t KIND_PIXEL = 1'b0;
	localparam kind_t KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pix_t;

	// One line memory entry: the row two above and the row just above.
	typedef struct packed {
		pix_t older;
		pix_t prev;
	} line_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} res_t;

	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic             load_pix;
		logic             shift_in;
		logic             sum_en;
		logic             sum_shift;
		logic [2:0]       col_v;
		logic             top;
		logic             bottom;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} dp_cmd_t;

	typedef struct packed {
		logic sum_ready;
	} dp_stat_t;

	// ceil(2^20 / (2*count)); exact floor division for numerators below 2^13.
	function automatic logic [RECIP_W-1:0] recip_m(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] m;
		case (cnt)
			4'd1:    m = 20'd524288;
			4'd2:    m = 20'd262144;
			4'd3:    m = 20'd174763;
			4'd4:    m = 20'd131072;
			4'd6:    m = 20'd87382;
			4'd9:    m = 20'd58255;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bb3_rdiv.sv =====
// Rounded mean of one channel: (2*sum + count) / (2*count), half up.
// Uses the reciprocal table of bb3_pkg; purely combinational.
`default_nettype none

module bb3_rdiv
	import bb3_pkg::*;
(
	input  logic [SUM_W-1:0] sum,
	input  logic [CNT_W-1:0] cnt,
	output logic [PIX_W-1:0] mean
);

	localparam int NUM_W  = SUM_W + 1;
	localparam int PROD_W = NUM_W + RECIP_W;

	logic [NUM_W-1:0]  num;
	logic [PROD_W-1:0] prod;

	assign num  = {sum, 1'b0} + NUM_W'(cnt);
	assign prod = PROD_W'(num) * PROD_W'(recip_m(cnt));
	assign mean = prod[RECIP_SHIFT +: PIX_W];

endmodule

`default_nettype wire

// ===== rtl/bb3_ctrl.sv =====
// Controller of the box blur: frame counters, size registers and the sequencer
// that issues commands to bb3_dp. Depends on bb3_pkg.
`default_nettype none

module bb3_ctrl
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int CW  = $clog2(MAX_WIDTH + 1),
	localparam int CW1 = CW + 1,
	localparam int HW  = $clog2(MAX_HEIGHT + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  kind_t            kind,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  reg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  dp_stat_t         stat,
	output dp_cmd_t          cmd,
	output logic [AW-1:0]    mem_addr
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRD,
		S_EMA,
		S_EMB,
		S_FR0,
		S_FR1,
		S_FR2,
		S_FEM
	} state_t;

	state_t         state_q, state_d;
	logic [CW-1:0]  w_q, col_q, drain_q;
	logic [HW-1:0]  h_q, row_q;
	logic [CW-1:0]  cfg_w_eff;
	logic [HW-1:0]  cfg_h_eff;
	logic           in_acc, cfg_acc;
	logic           row_in, col_in, col_last;
	logic           row_ge1, row_ge2, col_ge1, col_ge2, h_ge2;
	logic [CW-1:0]  d_eff, d_dec;
	logic [CW1-1:0] d_inc;
	logic           d_ge1, d_last;
	logic           fin_pix, fin_flush;

	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// A size of zero counts as one; a size above the maximum is clamped.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_w_eff = CW'(1);
			cfg_h_eff = HW'(1);
		end else begin
			cfg_w_eff = (32'(cfg_data) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : CW'(cfg_data);
			cfg_h_eff = (32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
		end
	end

	assign row_in   = row_q < h_q;
	assign col_in   = col_q < w_q;
	assign col_last = ({1'b0, col_q} + CW1'(1)) >= {1'b0, w_q};
	assign row_ge1  = row_q != '0;
	assign row_ge2  = row_q > HW'(1);
	assign col_ge1  = col_q != '0;
	assign col_ge2  = col_q > CW'(1);
	assign h_ge2    = h_q > HW'(1);

	assign d_eff  = (drain_q >= w_q) ? (w_q - CW'(1)) : drain_q;
	assign d_dec  = d_eff - CW'(1);
	assign d_inc  = {1'b0, d_eff} + CW1'(1);
	assign d_ge1  = d_eff != '0;
	assign d_last = d_inc >= {1'b0, w_q};

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		mem_addr  = col_q[AW-1:0];
		fin_pix   = 1'b0;
		fin_flush = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (kind == KIND_PIXEL) begin
						// Pixels beyond the last row are dropped.
						if (row_in && col_in) begin
							cmd.rd_en    = 1'b1;
							cmd.load_pix = 1'b1;
							state_d      = S_PRD;
						end
					end else if (!row_in) begin
						cmd.rd_en = 1'b1;
						mem_addr  = d_ge1 ? d_dec[AW-1:0] : '0;
						state_d   = S_FR0;
					end
				end
			end
			S_PRD: begin
				cmd.shift_in = 1'b1;
				cmd.wr_en    = 1'b1;
				if (row_ge1 && col_ge1) begin
					state_d = S_EMA;
				end else if (row_ge1 && col_last) begin
					state_d = S_EMB;
				end else begin
					fin_pix = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_EMA: begin
				cmd.top    = row_ge2;
				cmd.bottom = 1'b1;
				cmd.col_v  = {1'b1, 1'b1, col_ge2};
				cmd.row    = POS_W'(row_q - HW'(1));
				cmd.col    = POS_W'(col_q - CW'(1));
				if (stat.sum_ready) begin
					cmd.sum_en = 1'b1;
					if (col_last) begin
						state_d = S_EMB;
					end else begin
						fin_pix = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_EMB: begin
				// Right edge: the two newest columns, nothing beyond them.
				cmd.sum_shift = 1'b1;
				cmd.top       = row_ge2;
				cmd.bottom    = 1'b1;
				cmd.col_v     = {1'b0, 1'b1, col_ge1};
				cmd.row       = POS_W'(row_q - HW'(1));
				cmd.col       = POS_W'(col_q);
				if (stat.sum_ready) begin
					cmd.sum_en = 1'b1;
					fin_pix    = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_FR0: begin
				cmd.shift_in = 1'b1;
				cmd.rd_en    = 1'b1;
				mem_addr     = d_eff[AW-1:0];
				state_d      = S_FR1;
			end
			S_FR1: begin
				cmd.shift_in = 1'b1;
				cmd.rd_en    = 1'b1;
				mem_addr     = d_inc[AW-1:0];
				state_d      = S_FR2;
			end
			S_FR2: begin
				cmd.shift_in = 1'b1;
				state_d      = S_FEM;
			end
			S_FEM: begin
				cmd.top    = h_ge2;
				cmd.bottom = 1'b0;
				cmd.col_v  = {!d_last, 1'b1, d_ge1};
				cmd.row    = POS_W'(h_q - HW'(1));
				cmd.col    = POS_W'(d_eff);
				cmd.last   = d_last;
				if (stat.sum_ready) begin
					cmd.sum_en = 1'b1;
					fin_flush  = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			w_q     <= CW'(1);
			h_q     <= HW'(1);
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  w_q <= cfg_w_eff;
					REG_FRAME_HEIGHT: h_q <= cfg_h_eff;
					default: ;
				endcase
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= '0;
			end else if (fin_pix) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_q + HW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (fin_flush) begin
				// The last pixel of the drain starts a new frame.
				if (d_last) begin
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= '0;
				end else begin
					drain_q <= d_inc[CW-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bb3_dp.sv =====
// Datapath of the box blur: line memory, 3x3 window, neighborhood sums and
// the rounding stage with the output register. Depends on bb3_pkg, bb3_rdiv.
`default_nettype none

module bb3_dp
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pix_t          pix_in,
	input  dp_cmd_t       cmd,
	input  logic [AW-1:0] mem_addr,
	output dp_stat_t      stat,
	output logic          out_valid,
	input  logic          out_ready,
	output res_t          res
);

	line_t            mem [MAX_WIDTH];
	line_t            rd_q;
	pix_t             pix_q;
	pix_t             win_q [9];
	pix_t             tap [9];
	logic [8:0]       incl;
	logic [SUM_W-1:0] sum_r, sum_g, sum_b;
	logic [CNT_W-1:0] cnt;

	logic             s1_v_q, out_v_q, advance;
	logic [SUM_W-1:0] sum_r_s1, sum_g_s1, sum_b_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic [POS_W-1:0] row_s1, col_s1;
	logic             last_s1;
	logic [PIX_W-1:0] mean_r, mean_g, mean_b;
	res_t             res_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[mem_addr] <= '{older: rd_q.prev, prev: pix_q};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[mem_addr];
		end
	end

	// Window is column-major: index col*3 + row, rows top, middle, bottom.
	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			pix_q <= pix_in;
		end
		if (cmd.shift_in) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= win_q[i+3];
			end
			win_q[6] <= rd_q.older;
			win_q[7] <= rd_q.prev;
			win_q[8] <= pix_q;
		end
	end

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int j = 0; j < 3; j++) begin
			for (int r = 0; r < 3; r++) begin
				tap[j*3+r]  = (cmd.sum_shift && j < 2) ? win_q[(j+1)*3+r] : win_q[j*3+r];
				incl[j*3+r] = cmd.col_v[j] && (r != 0 || cmd.top) && (r != 2 || cmd.bottom);
			end
		end
		for (int i = 0; i < 9; i++) begin
			if (incl[i]) begin
				sum_r = sum_r + SUM_W'(tap[i].red);
				sum_g = sum_g + SUM_W'(tap[i].green);
				sum_b = sum_b + SUM_W'(tap[i].blue);
			end
		end
		cnt = CNT_W'($countones(incl));
	end

	assign advance = s1_v_q && (!out_v_q || out_ready);
	assign stat    = '{sum_ready: (!s1_v_q || advance)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.sum_en) begin
				s1_v_q <= 1'b1;
			end else if (advance) begin
				s1_v_q <= 1'b0;
			end
			if (advance) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			sum_r_s1 <= sum_r;
			sum_g_s1 <= sum_g;
			sum_b_s1 <= sum_b;
			cnt_s1   <= cnt;
			row_s1   <= cmd.row;
			col_s1   <= cmd.col;
			last_s1  <= cmd.last;
		end
		if (advance) begin
			res_q <= '{red: mean_r, green: mean_g, blue: mean_b,
				row: row_s1, col: col_s1, last: last_s1};
		end
	end

	bb3_rdiv u_rdiv_r (.sum(sum_r_s1), .cnt(cnt_s1), .mean(mean_r));
	bb3_rdiv u_rdiv_g (.sum(sum_g_s1), .cnt(cnt_s1), .mean(mean_g));
	bb3_rdiv u_rdiv_b (.sum(sum_b_s1), .cnt(cnt_s1), .mean(mean_b));

	assign out_valid = out_v_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== rtl/box_blur_3x3_edge_average.sv =====
// Top level of the 3x3 box blur with edge-aware averaging.
// Depends on bb3_pkg, bb3_ctrl and bb3_dp.
//
// Pixels enter in raster order; each result is the half-up rounded mean of
// the in-bounds 3x3 neighborhood, tagged with its row and column. The result
// for a pixel leaves once the pixel below and to the right has arrived (the
// pixel below for the last column); the last row comes out one result per
// flush request, and the final one carries frame_last and starts a new frame.
// Writing either size register also starts a new frame. A pixel request
// occupies the controller for one line memory read, one write-back, then
// one sum state per result it completes; a flush request for three line
// memory reads through a single port, then the sum; and a request that is
// ignored leaves it idle. Results pass through the sum register and then
// the output register, and a held output stalls the sequencer only when
// the sum stage behind it is also full.
`default_nettype none

module box_blur_3x3_edge_average
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  kind_t            kind,
	input  logic [PIX_W-1:0] in_red,
	input  logic [PIX_W-1:0] in_green,
	input  logic [PIX_W-1:0] in_blue,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_red,
	output logic [PIX_W-1:0] out_green,
	output logic [PIX_W-1:0] out_blue,
	output logic [POS_W-1:0] out_row,
	output logic [POS_W-1:0] out_col,
	output logic             frame_last,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  reg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [AW-1:0] mem_addr;
	pix_t          pix_in;
	res_t          res;

	assign pix_in = '{red: in_red, green: in_green, blue: in_blue};

	bb3_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.stat     (stat),
		.cmd      (cmd),
		.mem_addr (mem_addr)
	);

	bb3_dp #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.cmd      (cmd),
		.mem_addr (mem_addr),
		.stat     (stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res      (res)
	);

	assign out_red    = res.red;
	assign out_green  = res.green;
	assign out_blue   = res.blue;
	assign out_row    = res.row;
	assign out_col    = res.col;
	assign frame_last = res.last;

endmodule

`default_nettype wire

// ===== rtl/bb3_chk.sv =====
// Port-level checker for the box blur top level, attached by a bind.
// Depends on bb3_pkg and box_blur_3x3_edge_average.
`default_nettype none

module bb3_chk
	import bb3_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input kind_t            kind,
	input logic [PIX_W-1:0] in_red,
	input logic [PIX_W-1:0] in_green,
	input logic [PIX_W-1:0] in_blue,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PIX_W-1:0] out_red,
	input logic [PIX_W-1:0] out_green,
	input logic [PIX_W-1:0] out_blue,
	input logic [POS_W-1:0] out_row,
	input logic [POS_W-1:0] out_col,
	input logic             frame_last,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input reg_idx_t         cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	// A result that is not taken stays, unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_row) && $stable(out_col)
			&& $stable(frame_last))
		else $error("result changed or dropped while stalled");

	// A pending register write keeps pixel requests out.
	a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> !in_ready)
		else $error("input ready during a register write");

	// A register write leaves the block idle.
	a_cfg_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> cfg_ready)
		else $error("block left idle after a register write");

	// The input side is only open when the block is idle.
	a_in_implies_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cfg_ready)
		else $error("input ready while the sequencer is busy");

endmodule

bind box_blur_3x3_edge_average bb3_chk u_chk (.*);

`default_nettype wire
